// ===== rtl/asmtok_pkg.sv =====
// asmtok_pkg: types and character constants of the assembly line tokenizer.
// No dependencies; imported by every module of the block.
package asmtok_pkg;

  localparam int CHAR_W    = 8;
  localparam int DEPTH_W   = 8;
  localparam int NUMBER_W  = 4;
  localparam int COUNT_W   = 5;
  // Token counter is widened to this before slicing the output fields.
  localparam int CNT_EXT_W = 6;

  localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h22;
  localparam logic [CHAR_W-1:0] CH_HASH   = 8'h23;
  localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;
  localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [CHAR_W-1:0] CH_RBRACK = 8'h5D;

  typedef enum logic [2:0] {
    MODE_BETWEEN = 3'd0,
    MODE_PLAIN   = 3'd1,
    MODE_QUOTE   = 3'd2,
    MODE_QESC    = 3'd3,
    MODE_BRACKET = 3'd4,
    MODE_TERM    = 3'd5,
    MODE_DONE    = 3'd6
  } scan_mode_t;

  typedef enum logic [2:0] {
    ROLE_SEP   = 3'd0,
    ROLE_START = 3'd1,
    ROLE_BODY  = 3'd2,
    ROLE_TERM  = 3'd3,
    ROLE_IGN   = 3'd4
  } char_role_t;

  typedef struct packed {
    logic is_nul;
    logic is_sep;
    logic is_comment;
    logic is_newline;
    logic is_quote;
    logic is_escape;
    logic is_open;
    logic is_close;
  } char_class_t;

  typedef struct packed {
    char_role_t          role;
    logic [NUMBER_W-1:0] token_number;
    logic                line_error;
    logic [COUNT_W-1:0]  token_count;
    logic                line_end;
  } result_t;

endpackage

// ===== rtl/asmtok_classify.sv =====
// asmtok_classify: decodes one source character into class flags.
// Depends on asmtok_pkg.
module asmtok_classify import asmtok_pkg::*; (
  input  logic [CHAR_W-1:0] char_in,
  output char_class_t       cls
);

  always_comb begin
    cls.is_nul     = (char_in == CH_NUL);
    cls.is_sep     = (char_in == CH_SPACE) || (char_in == CH_TAB) || (char_in == CH_COMMA);
    cls.is_comment = (char_in == CH_HASH) || (char_in == CH_SEMI);
    cls.is_newline = (char_in == CH_LF) || (char_in == CH_CR);
    cls.is_quote   = (char_in == CH_QUOTE);
    cls.is_escape  = (char_in == CH_BSLASH);
    cls.is_open    = (char_in == CH_LBRACK);
    cls.is_close   = (char_in == CH_RBRACK);
  end

endmodule

// ===== rtl/asmtok_scan.sv =====
// asmtok_scan: line scan state (mode, bracket depth, token count, error)
// and the per-character role decision. Depends on asmtok_pkg.
module asmtok_scan import asmtok_pkg::*; #(
  parameter int MAX_TOKENS = 16,
  parameter int DEPTH_MAX  = 255
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  char_class_t cls,
  input  logic        line_last,
  output result_t     result
);

  localparam int TOK_W = $clog2(MAX_TOKENS + 1);

  scan_mode_t         mode, mode_next;
  logic [DEPTH_W-1:0] depth, depth_next;
  logic [TOK_W-1:0]   tokens, tokens_next;
  logic               error, error_next;
  char_role_t         role;
  logic [CNT_EXT_W-1:0] tokens_ext;
  logic [CNT_EXT_W-1:0] number_ext;

  always_comb begin
    mode_next   = mode;
    depth_next  = depth;
    tokens_next = tokens;
    error_next  = error;
    role        = ROLE_IGN;
    if (cls.is_nul) begin
      mode_next = MODE_DONE;
    end else begin
      unique case (mode)
        MODE_BETWEEN: begin
          if (cls.is_sep) begin
            role = ROLE_SEP;
          end else if (cls.is_comment || cls.is_newline) begin
            mode_next = MODE_DONE;
          end else if (tokens >= TOK_W'(MAX_TOKENS)) begin
            // token limit hit: flag and stop the line
            error_next = 1'b1;
            mode_next  = MODE_DONE;
          end else begin
            role        = ROLE_START;
            tokens_next = tokens + TOK_W'(1);
            if (cls.is_quote) begin
              mode_next = MODE_QUOTE;
            end else if (cls.is_open) begin
              depth_next = DEPTH_W'(1);
              mode_next  = MODE_BRACKET;
            end else begin
              mode_next = MODE_PLAIN;
            end
          end
        end
        MODE_PLAIN: begin
          role = ROLE_TERM;
          if (cls.is_sep || cls.is_newline) begin
            mode_next = MODE_BETWEEN;
          end else if (cls.is_comment) begin
            mode_next = MODE_DONE;
          end else begin
            role = ROLE_BODY;
          end
        end
        MODE_QUOTE: begin
          role = ROLE_BODY;
          if (cls.is_quote) begin
            mode_next = MODE_TERM;
          end else if (cls.is_escape) begin
            mode_next = MODE_QESC;
          end
        end
        MODE_QESC: begin
          role      = ROLE_BODY;
          mode_next = MODE_QUOTE;
        end
        MODE_BRACKET: begin
          role = ROLE_BODY;
          if (cls.is_open) begin
            if (depth < DEPTH_W'(DEPTH_MAX)) begin
              depth_next = depth + DEPTH_W'(1);
            end
          end else if (cls.is_close) begin
            if (depth != '0) begin
              depth_next = depth - DEPTH_W'(1);
            end
            if (depth_next == '0) begin
              mode_next = MODE_TERM;
            end
          end
        end
        MODE_TERM: begin
          role      = ROLE_TERM;
          mode_next = MODE_BETWEEN;
        end
        default: begin
          mode_next = MODE_DONE;
        end
      endcase
    end
  end

  // outputs use the counter after this character
  assign tokens_ext = CNT_EXT_W'(tokens_next);
  assign number_ext = tokens_ext - CNT_EXT_W'(1);

  always_comb begin
    result.role        = role;
    result.line_error  = error_next;
    result.token_count = tokens_ext[COUNT_W-1:0];
    result.line_end    = line_last;
    if (role == ROLE_START || role == ROLE_BODY || role == ROLE_TERM) begin
      result.token_number = number_ext[NUMBER_W-1:0];
    end else begin
      result.token_number = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_BETWEEN;
      depth  <= '0;
      tokens <= '0;
      error  <= 1'b0;
    end else if (advance) begin
      if (line_last) begin
        mode   <= MODE_BETWEEN;
        depth  <= '0;
        tokens <= '0;
        error  <= 1'b0;
      end else begin
        mode   <= mode_next;
        depth  <= depth_next;
        tokens <= tokens_next;
        error  <= error_next;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_tokens_bounded: assert property (@(posedge clk) disable iff (rst)
    tokens <= TOK_W'(MAX_TOKENS))
    else $error("token counter beyond limit");

  a_error_stops_scan: assert property (@(posedge clk) disable iff (rst)
    error |-> mode == MODE_DONE)
    else $error("error flag set while scan still running");

  a_bracket_depth_live: assert property (@(posedge clk) disable iff (rst)
    mode == MODE_BRACKET |-> depth != '0)
    else $error("bracket mode with zero depth");

  a_line_clears: assert property (@(posedge clk) disable iff (rst)
    advance && line_last |=> tokens == '0 && !error && mode == MODE_BETWEEN)
    else $error("state not cleared after last character");
`endif

endmodule

// ===== rtl/assembly_line_tokenizer.sv =====
// assembly_line_tokenizer: top level; input register, character decode,
// scan state and result register. Depends on asmtok_pkg, asmtok_classify, asmtok_scan.
//
//   channel  handshake              request fields
//   input    in_valid / in_stall    char_in, line_last
//   output   out_valid / out_stall  char_role, token_number, line_error, token_count, line_end
//
// One character per cycle sustained while out_stall is low; a character goes from
// input request to result through the input register, then the result register.
// The scan state updates as a character moves into the result register,
// so consecutive characters of a line follow back to back.
// rst is synchronous and clears both stage valids and the scan state.
// A stall on the output holds the result; the input register keeps
// accepting while the result register is free or draining.
module assembly_line_tokenizer import asmtok_pkg::*; #(
  parameter int MAX_TOKENS = 16,
  parameter int DEPTH_MAX  = 255
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [CHAR_W-1:0]   char_in,
  input  logic                line_last,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          char_role,
  output logic [NUMBER_W-1:0] token_number,
  output logic                line_error,
  output logic [COUNT_W-1:0]  token_count,
  output logic                line_end
);

  char_class_t in_cls;
  char_class_t s1_cls;
  logic        s1_last;
  logic        s1_valid;
  logic        advance;
  logic        accept;
  result_t     scan_res;
  result_t     res;

  // decode before the input register keeps the scan path short
  asmtok_classify u_classify (
    .char_in (char_in),
    .cls     (in_cls)
  );

  // stage 1 moves on when the result register is empty or draining
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cls  <= in_cls;
      s1_last <= line_last;
    end
  end

  asmtok_scan #(
    .MAX_TOKENS (MAX_TOKENS),
    .DEPTH_MAX  (DEPTH_MAX)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .cls       (s1_cls),
    .line_last (s1_last),
    .result    (scan_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= scan_res;
    end
  end

  assign char_role    = res.role;
  assign token_number = res.token_number;
  assign line_error   = res.line_error;
  assign token_count  = res.token_count;
  assign line_end     = res.line_end;

`ifndef NO_ASSERTIONS
  a_number_zero_off_token: assert property (@(posedge clk) disable iff (rst)
    out_valid && (res.role == ROLE_SEP || res.role == ROLE_IGN) |-> token_number == '0)
    else $error("token number set on a non-token character");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && out_stall |-> in_stall && !advance)
    else $error("input taken while both stages are held");

  a_start_counts: assert property (@(posedge clk) disable iff (rst)
    out_valid && res.role == ROLE_START |-> token_count != '0 || MAX_TOKENS == 32)
    else $error("token start without a counted token");
`endif

endmodule
